### sv/kabf_pkg.sv
// Package for the angle and gyro-bias Kalman filter core.
// Holds the register map, the sequencer state type and fixed constants.
// No dependencies.
`default_nettype none

package kabf_pkg;

    // register map, index = byte address / 4
    typedef enum logic [1:0] {
        REG_TIME_STEP     = 2'd0,
        REG_ANGLE_NOISE   = 2'd1,
        REG_BIAS_NOISE    = 2'd2,
        REG_MEASURE_NOISE = 2'd3
    } kabf_reg_t;

    localparam logic [31:0] TIME_STEP_RST     = 32'd42950;
    localparam logic [31:0] ANGLE_NOISE_RST   = 32'd16777;
    localparam logic [31:0] BIAS_NOISE_RST    = 32'd50332;
    localparam logic [31:0] MEASURE_NOISE_RST = 32'd503316;

    // initial covariance diagonal, 1000.0 with 32 fraction bits
    localparam logic [63:0] COV_INIT_RAW = 64'd1000 << 32;

    // serial multiplier digit
    localparam int unsigned DIGIT_BITS = 4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUB_RB,
        ST_MUL_RB,
        ST_ADD_PP,
        ST_MUL_PBB,
        ST_SUB_QA,
        ST_MUL_T,
        ST_SUB_AB,
        ST_MUL_QB,
        ST_INNOV,
        ST_DIV_K0,
        ST_DIV_K1,
        ST_MUL_K0Y,
        ST_MUL_K1Y,
        ST_MUL_K1A,
        ST_MUL_K1B,
        ST_MUL_K0A,
        ST_MUL_K0B,
        ST_DONE
    } kabf_state_t;

endpackage

`default_nettype wire

### sv/kalman_angle_bias_filter_core.sv
// Top level of the two-state Kalman filter (angle and gyro bias); depends on kabf_pkg.
// A sample is taken only in idle; the result reaches out_valid after the whole predict and
//   update sequence, which skips the divides when S is not positive.
// No new sample is taken until the last result is registered; a held result stalls the core.
// Built on one shared multiplier taking 4 bits a cycle and one restoring divider, 1 bit a cycle.
// Reset (rst_n low, asynchronous): registers to reset values, estimates zero, covariance diagonal 1000.0.
`default_nettype none

module kalman_angle_bias_filter_core
    import kabf_pkg::*;
#(
    parameter int unsigned STATE_WIDTH = 48
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // sample channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] measured_angle,
    input  wire logic signed [31:0] angular_rate,
    input  wire logic               restart,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      angle_estimate,
    output logic signed [31:0]      bias_estimate,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int unsigned W    = STATE_WIDTH;
    // multiplier: digits of the second operand, product register width
    localparam int unsigned MN   = (W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int unsigned MB   = MN * DIGIT_BITS;
    localparam int unsigned PW   = W + MB;
    localparam int unsigned MCW  = $clog2(MN);
    // divider: one quotient bit per step
    localparam int unsigned DN   = W + 32;
    localparam int unsigned DCW  = $clog2(DN);

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [64:0]  MAX65 = {{(65-W){1'b0}}, SMAX};
    localparam logic signed [64:0]  MIN65 = {{(65-W){1'b1}}, SMIN};
    localparam logic signed [64:0]  O32MAX = 65'sd2147483647;
    localparam logic signed [64:0]  O32MIN = -65'sd2147483648;

    // ------------------------------------------------------------------
    // Saturation helpers
    // ------------------------------------------------------------------
    function automatic logic signed [W-1:0] sat_wide(input logic signed [64:0] x);
        if (x > MAX65)
            return SMAX;
        else if (x < MIN65)
            return SMIN;
        else
            return x[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat1(input logic signed [W:0] x);
        if (x[W] != x[W-1])
            return x[W] ? SMIN : SMAX;
        else
            return x[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return sat1({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return sat1({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] magn(input logic signed [W-1:0] a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    // drop 16 fraction bits toward zero, then clamp to 32 bits
    function automatic logic signed [31:0] to_out(input logic signed [W-1:0] x);
        logic [W-1:0]      ax;
        logic signed [64:0] v;
        ax = magn(x);
        v  = {{(65-W){1'b0}}, ax >> 16};
        if (x[W-1])
            v = -v;
        if (v > O32MAX)
            return 32'sh7fffffff;
        else if (v < O32MIN)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [31:0] time_step_reg, angle_noise_reg, bias_noise_reg, measure_noise_reg;
    logic        cfg_wr;
    kabf_reg_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = kabf_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg     <= TIME_STEP_RST;
            angle_noise_reg   <= ANGLE_NOISE_RST;
            bias_noise_reg    <= BIAS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TIME_STEP:     time_step_reg     <= pwdata;
                REG_ANGLE_NOISE:   angle_noise_reg   <= pwdata;
                REG_BIAS_NOISE:    bias_noise_reg    <= pwdata;
                REG_MEASURE_NOISE: measure_noise_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TIME_STEP:     prdata = time_step_reg;
            REG_ANGLE_NOISE:   prdata = angle_noise_reg;
            REG_BIAS_NOISE:    prdata = bias_noise_reg;
            REG_MEASURE_NOISE: prdata = measure_noise_reg;
        endcase
    end

    // noise terms move from 24 to 32 fraction bits; dt is a plain fraction
    logic signed [W-1:0] dt, qa, qb, rm;
    assign dt = {{(W-32){1'b0}}, time_step_reg};
    assign qa = sat_wide({25'b0, angle_noise_reg, 8'b0});
    assign qb = sat_wide({25'b0, bias_noise_reg, 8'b0});
    assign rm = sat_wide({25'b0, measure_noise_reg, 8'b0});

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    kabf_state_t state_reg, state_next;
    logic        issued_reg, issued_next;
    logic        mul_start, div_start, mul_done_reg, div_done_reg;
    logic        s_pos, out_free;
    logic signed [W-1:0] s_reg;

    assign s_pos    = !s_reg[W-1] && (|s_reg);
    assign out_free = !out_valid || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_SUB_RB;
            ST_SUB_RB:  state_next = ST_MUL_RB;
            ST_MUL_RB:  if (mul_done_reg) state_next = ST_ADD_PP;
            ST_ADD_PP:  state_next = ST_MUL_PBB;
            ST_MUL_PBB: if (mul_done_reg) state_next = ST_SUB_QA;
            ST_SUB_QA:  state_next = ST_MUL_T;
            ST_MUL_T:   if (mul_done_reg) state_next = ST_SUB_AB;
            ST_SUB_AB:  state_next = ST_MUL_QB;
            ST_MUL_QB:  if (mul_done_reg) state_next = ST_INNOV;
            ST_INNOV:   state_next = ST_DIV_K0;
            ST_DIV_K0:
            begin
                priority if (!s_pos)
                    state_next = ST_MUL_K0Y;
                else if (div_done_reg)
                    state_next = ST_DIV_K1;
                else
                    state_next = ST_DIV_K0;
            end
            ST_DIV_K1:  if (div_done_reg) state_next = ST_MUL_K0Y;
            ST_MUL_K0Y: if (mul_done_reg) state_next = ST_MUL_K1Y;
            ST_MUL_K1Y: if (mul_done_reg) state_next = ST_MUL_K1A;
            ST_MUL_K1A: if (mul_done_reg) state_next = ST_MUL_K1B;
            ST_MUL_K1B: if (mul_done_reg) state_next = ST_MUL_K0A;
            ST_MUL_K0A: if (mul_done_reg) state_next = ST_MUL_K0B;
            ST_MUL_K0B: if (mul_done_reg) state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    logic is_mul, is_div;
    always_comb
    begin
        is_mul = 1'b0;
        is_div = 1'b0;
        unique case (state_reg)
            ST_MUL_RB, ST_MUL_PBB, ST_MUL_T, ST_MUL_QB, ST_MUL_K0Y,
            ST_MUL_K1Y, ST_MUL_K1A, ST_MUL_K1B, ST_MUL_K0A, ST_MUL_K0B:
                is_mul = 1'b1;
            ST_DIV_K0, ST_DIV_K1:
                is_div = 1'b1;
            default: ;
        endcase
        in_ready  = (state_reg == ST_IDLE);
        mul_start = is_mul && !issued_reg;
        div_start = is_div && !issued_reg && s_pos;
        if (is_mul)
            issued_next = !mul_done_reg;
        else if (is_div)
            issued_next = s_pos && !div_done_reg;
        else
            issued_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    // ------------------------------------------------------------------
    // Filter state and scratch registers
    // ------------------------------------------------------------------
    logic signed [W-1:0] ang_reg, bia_reg, paa_reg, pab_reg, pba_reg, pbb_reg;
    logic signed [W-1:0] meas_reg, rate_reg, t_reg, tb_reg, y_reg, k0_reg, k1_reg;
    logic signed [W-1:0] mres, dres, cov_init;

    assign cov_init = sat_wide({1'b0, COV_INIT_RAW});

    // operand selection for the shared multiplier and divider
    logic signed [W-1:0] mop_a, mop_b, dnum;
    always_comb
    begin
        mop_a = dt;
        mop_b = t_reg;
        unique case (state_reg)
            ST_MUL_PBB: mop_b = pbb_reg;
            ST_MUL_QB:  mop_b = qb;
            ST_MUL_K0Y: begin mop_a = k0_reg; mop_b = y_reg;   end
            ST_MUL_K1Y: begin mop_a = k1_reg; mop_b = y_reg;   end
            ST_MUL_K1A: begin mop_a = k1_reg; mop_b = paa_reg; end
            ST_MUL_K1B: begin mop_a = k1_reg; mop_b = pab_reg; end
            ST_MUL_K0A: begin mop_a = k0_reg; mop_b = paa_reg; end
            ST_MUL_K0B: begin mop_a = k0_reg; mop_b = pab_reg; end
            default: ;
        endcase
        dnum = (state_reg == ST_DIV_K1) ? pba_reg : paa_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg <= '0;
            bia_reg <= '0;
            paa_reg <= cov_init;
            pab_reg <= '0;
            pba_reg <= '0;
            pbb_reg <= cov_init;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        meas_reg <= sat_wide({{17{measured_angle[31]}}, measured_angle, 16'b0});
                        rate_reg <= sat_wide({{17{angular_rate[31]}}, angular_rate, 16'b0});
                        // restart: drop the estimates before this sample
                        if (restart)
                        begin
                            ang_reg <= '0;
                            bia_reg <= '0;
                            paa_reg <= cov_init;
                            pab_reg <= '0;
                            pba_reg <= '0;
                            pbb_reg <= cov_init;
                        end
                    end
                end
                ST_SUB_RB:  t_reg <= ssub(rate_reg, bia_reg);
                ST_MUL_RB:  if (mul_done_reg) ang_reg <= sadd(ang_reg, mres);
                ST_ADD_PP:  t_reg <= sadd(pab_reg, pba_reg);
                ST_MUL_PBB:
                begin
                    if (mul_done_reg)
                    begin
                        t_reg  <= ssub(t_reg, mres);
                        tb_reg <= mres;
                    end
                end
                ST_SUB_QA:  t_reg <= ssub(t_reg, qa);
                ST_MUL_T:   if (mul_done_reg) paa_reg <= ssub(paa_reg, mres);
                ST_SUB_AB:
                begin
                    pab_reg <= ssub(pab_reg, tb_reg);
                    pba_reg <= ssub(pba_reg, tb_reg);
                end
                ST_MUL_QB:  if (mul_done_reg) pbb_reg <= sadd(pbb_reg, mres);
                ST_INNOV:
                begin
                    y_reg <= ssub(meas_reg, ang_reg);
                    s_reg <= sadd(paa_reg, rm);
                end
                ST_DIV_K0:
                begin
                    // non-positive innovation variance: zero gains
                    priority if (!s_pos)
                    begin
                        k0_reg <= '0;
                        k1_reg <= '0;
                    end
                    else
                    begin
                        if (div_done_reg)
                            k0_reg <= dres;
                    end
                end
                ST_DIV_K1:  if (div_done_reg) k1_reg <= dres;
                ST_MUL_K0Y: if (mul_done_reg) ang_reg <= sadd(ang_reg, mres);
                ST_MUL_K1Y: if (mul_done_reg) bia_reg <= sadd(bia_reg, mres);
                // second row first, so it sees the uncorrected p00 and p01
                ST_MUL_K1A: if (mul_done_reg) pba_reg <= ssub(pba_reg, mres);
                ST_MUL_K1B: if (mul_done_reg) pbb_reg <= ssub(pbb_reg, mres);
                ST_MUL_K0A: if (mul_done_reg) paa_reg <= ssub(paa_reg, mres);
                ST_MUL_K0B: if (mul_done_reg) pab_reg <= ssub(pab_reg, mres);
                ST_DONE: ;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Serial multiplier: magnitude product, 4 bits of mop_b per cycle
    // ------------------------------------------------------------------
    logic [W-1:0]   mu_a_reg;
    logic [PW-1:0]  mu_pr_reg;
    logic           mu_neg_reg, mu_busy_reg;
    logic [MCW-1:0] mu_cnt_reg;
    logic [W+3:0]   mu_sum;
    logic           mu_ovf;
    logic [W-2:0]   mu_mag;

    assign mu_sum = (W+4)'(mu_pr_reg[PW-1:MB])
                  + (W+4)'(mu_a_reg) * (W+4)'(mu_pr_reg[DIGIT_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_busy_reg  <= 1'b0;
            mul_done_reg <= 1'b0;
            mu_cnt_reg   <= '0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (mul_start)
            begin
                mu_busy_reg <= 1'b1;
                mu_cnt_reg  <= '0;
            end
            else if (mu_busy_reg)
            begin
                mu_cnt_reg <= mu_cnt_reg + 1'b1;
                if (mu_cnt_reg == MCW'(MN - 1))
                begin
                    mu_busy_reg  <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            mu_a_reg   <= magn(mop_a);
            mu_pr_reg  <= PW'(magn(mop_b));
            mu_neg_reg <= mop_a[W-1] ^ mop_b[W-1];
        end
        else if (mu_busy_reg)
            mu_pr_reg <= {mu_sum, mu_pr_reg[MB-1:DIGIT_BITS]};
    end

    // keep 32 fraction bits, clamp where the magnitude leaves the range
    assign mu_ovf = |mu_pr_reg[PW-1:W+31];
    assign mu_mag = mu_pr_reg[W+30:32];
    always_comb
    begin
        if (mu_ovf)
            mres = mu_neg_reg ? SMIN : SMAX;
        else if (mu_neg_reg)
            mres = -$signed({1'b0, mu_mag});
        else
            mres = $signed({1'b0, mu_mag});
    end

    // ------------------------------------------------------------------
    // Serial divider: restoring, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [W-1:0]   dv_d_reg, dv_rem_reg;
    logic [DN-1:0]  dv_q_reg;
    logic           dv_neg_reg, dv_busy_reg;
    logic [DCW-1:0] dv_cnt_reg;
    logic [W:0]     dv_trial;
    logic           dv_ovf;

    assign dv_trial = {dv_rem_reg, dv_q_reg[DN-1]} - {1'b0, dv_d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg  <= 1'b0;
            div_done_reg <= 1'b0;
            dv_cnt_reg   <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (div_start)
            begin
                dv_busy_reg <= 1'b1;
                dv_cnt_reg  <= '0;
            end
            else if (dv_busy_reg)
            begin
                dv_cnt_reg <= dv_cnt_reg + 1'b1;
                if (dv_cnt_reg == DCW'(DN - 1))
                begin
                    dv_busy_reg  <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dv_d_reg   <= s_reg;
            dv_rem_reg <= '0;
            dv_q_reg   <= {magn(dnum), 32'b0};
            dv_neg_reg <= dnum[W-1];
        end
        else if (dv_busy_reg)
        begin
            if (!dv_trial[W])
                dv_rem_reg <= dv_trial[W-1:0];
            else
                dv_rem_reg <= {dv_rem_reg[W-2:0], dv_q_reg[DN-1]};
            dv_q_reg <= {dv_q_reg[DN-2:0], !dv_trial[W]};
        end
    end

    assign dv_ovf = |dv_q_reg[DN-1:W-1];
    always_comb
    begin
        if (dv_ovf)
            dres = dv_neg_reg ? SMIN : SMAX;
        else if (dv_neg_reg)
            dres = -$signed({1'b0, dv_q_reg[W-2:0]});
        else
            dres = $signed({1'b0, dv_q_reg[W-2:0]});
    end

    // ------------------------------------------------------------------
    // Result register: holds a transfer until taken, frees the sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (state_reg == ST_DONE && out_free)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            angle_estimate <= to_out(ang_reg);
            bias_estimate  <= to_out(bia_reg);
        end
    end

endmodule

`default_nettype wire

### sv/kabf_checker.sv
// Port-level checker for the Kalman filter core, bound to the top level.
// Depends on nothing but the top level's port names.
`default_nettype none

module kabf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] angle_estimate,
    input wire logic [31:0] bias_estimate,
    input wire logic        pready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_estimate)
                                    && $stable(bias_estimate))
        else $error("result changed while stalled");

    // a sample keeps the core busy for at least the next cycle
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("core accepted back to back samples");

    // a new result appears only once the sequencer has left idle
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared from idle");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind kalman_angle_bias_filter_core kabf_checker u_kabf_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for kalman_angle_bias_filter_core: random and directed samples,
// APB register changes between phases, a built-in predictor of the filter arithmetic.
// Depends on kabf_pkg (register map) and the core itself.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kabf_pkg::*;

    localparam longint STATE_MAX = (longint'(1) <<< 47) - 1;
    localparam longint STATE_MIN = -(longint'(1) <<< 47);
    localparam int unsigned LATENCY = 332;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        logic               restart;
    } sample_t;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } estimate_t;

    logic clk;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] measured_angle = '0;
    logic signed [31:0] angular_rate = '0;
    logic               restart = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    kalman_angle_bias_filter_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .measured_angle (measured_angle),
        .angular_rate   (angular_rate),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .angle_estimate (angle_estimate),
        .bias_estimate  (bias_estimate),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // samples waiting to be driven, estimates waiting to be seen
    sample_t   sample_q[$];
    estimate_t estimate_q[$];
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned errors = 0;

    // predictor's copy of the registers and the filter state
    longint unsigned dt_reg, qa_reg, qb_reg, rm_reg;
    longint angle_st, bias_st, p_aa, p_ab, p_ba, p_bb;

    // signed value from magnitude and sign, clipped to the 48-bit state range
    function automatic longint from_mag(logic [63:0] m, bit neg);
        if (neg)
            return (m > STATE_MAX) ? STATE_MIN : -longint'(m);
        return (m > STATE_MAX) ? STATE_MAX : longint'(m);
    endfunction

    function automatic logic [63:0] magnitude(longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic longint clip(longint a);
        return from_mag(magnitude(a), a < 0);
    endfunction

    // (a * b) >> 32, truncated toward zero
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        logic [127:0] r;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        r = p >> 32;
        if (r[127:64] != 0)
            r[63:0] = '1;
        return from_mag(r[63:0], (a < 0) != (b < 0));
    endfunction

    // (n << 32) / d for positive d, truncated toward zero
    function automatic longint fx_div(longint n, longint d);
        logic [127:0] q;
        q = ({64'd0, magnitude(n)} << 32) / {64'd0, 64'(d)};
        if (q[127:64] != 0)
            q[63:0] = '1;
        return from_mag(q[63:0], n < 0);
    endfunction

    function automatic logic signed [31:0] to_q16(longint s);
        longint v;
        v = s / 65536;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic clear_filter_state();
        angle_st = 0;
        bias_st = 0;
        p_aa = from_mag(COV_INIT_RAW, 1'b0);
        p_ab = 0;
        p_ba = 0;
        p_bb = p_aa;
    endtask

    // one predict and update step of the filter
    task automatic filter_step(sample_t s, output estimate_t e);
        longint dt, qa, qb, rm, meas, rate, t, y, sv, k0, k1, paa, pab;
        dt = longint'(dt_reg);
        qa = clip(longint'(qa_reg << 8));
        qb = clip(longint'(qb_reg << 8));
        rm = clip(longint'(rm_reg << 8));
        meas = clip(longint'(s.angle) * 65536);
        rate = clip(longint'(s.rate) * 65536);
        if (s.restart)
            clear_filter_state();
        angle_st = clip(angle_st + fx_mul(dt, clip(rate - bias_st)));
        t = clip(p_ab + p_ba);
        t = clip(t - fx_mul(dt, p_bb));
        t = clip(t - qa);
        p_aa = clip(p_aa - fx_mul(dt, t));
        t = fx_mul(dt, p_bb);
        p_ab = clip(p_ab - t);
        p_ba = clip(p_ba - t);
        p_bb = clip(p_bb + fx_mul(dt, qb));
        y = clip(meas - angle_st);
        sv = clip(p_aa + rm);
        // a non-positive innovation variance gives zero gain
        if (sv > 0)
        begin
            k0 = fx_div(p_aa, sv);
            k1 = fx_div(p_ba, sv);
        end
        else
        begin
            k0 = 0;
            k1 = 0;
        end
        angle_st = clip(angle_st + fx_mul(k0, y));
        bias_st = clip(bias_st + fx_mul(k1, y));
        // covariance correction uses the values from before the correction
        paa = p_aa;
        pab = p_ab;
        p_aa = clip(p_aa - fx_mul(k0, paa));
        p_ab = clip(p_ab - fx_mul(k0, pab));
        p_ba = clip(p_ba - fx_mul(k1, paa));
        p_bb = clip(p_bb - fx_mul(k1, pab));
        e.angle = to_q16(angle_st);
        e.bias = to_q16(bias_st);
    endtask

    // Driver: present the next sample once the current one has transferred,
    // with random gaps at the chosen rate.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (sample_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                sample_t s;
                s = sample_q.pop_front();
                in_valid <= 1'b1;
                measured_angle <= s.angle;
                angular_rate <= s.rate;
                restart <= s.restart;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: predict on each sample transfer, check on each result transfer,
    // and stall the result channel at random.
    always @(posedge clk)
    begin
        sample_t   s;
        estimate_t e;
        estimate_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                s.angle = measured_angle;
                s.rate = angular_rate;
                s.restart = restart;
                filter_step(s, e);
                estimate_q.push_back(e);
            end
            if (out_valid && out_ready)
            begin
                if (estimate_q.size() == 0)
                begin
                    $error("result with no sample waiting: angle %0d bias %0d",
                           angle_estimate, bias_estimate);
                    errors++;
                end
                else
                begin
                    want = estimate_q.pop_front();
                    if (angle_estimate !== want.angle)
                    begin
                        $error("angle_estimate: expected %0d, got %0d",
                               want.angle, angle_estimate);
                        errors++;
                    end
                    if (bias_estimate !== want.bias)
                    begin
                        $error("bias_estimate: expected %0d, got %0d",
                               want.bias, bias_estimate);
                        errors++;
                    end
                end
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    // APB write: setup cycle, access cycle; the register takes the value at the
    // edge closing the access cycle, and so does the predictor's copy.
    task automatic reg_write(kabf_reg_t r, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_TIME_STEP:     dt_reg = v;
            REG_ANGLE_NOISE:   qa_reg = v;
            REG_BIAS_NOISE:    qb_reg = v;
            REG_MEASURE_NOISE: rm_reg = v;
            default: ;
        endcase
    endtask

    task automatic set_filter_regs(logic [31:0] dt, logic [31:0] qa, logic [31:0] qb,
                                   logic [31:0] rm);
        reg_write(REG_TIME_STEP, dt);
        reg_write(REG_ANGLE_NOISE, qa);
        reg_write(REG_BIAS_NOISE, qb);
        reg_write(REG_MEASURE_NOISE, rm);
    endtask

    // hold off until every queued sample has transferred and every result is in
    task automatic drain();
        do
            @(negedge clk);
        while (sample_q.size() > 0 || in_valid || estimate_q.size() > 0);
    endtask

    task automatic add_sample(logic signed [31:0] a, logic signed [31:0] r, logic rs);
        sample_t s;
        s.angle = a;
        s.rate = r;
        s.restart = rs;
        sample_q.push_back(s);
    endtask

    // mostly plausible IMU readings, some full-range noise, rare restarts
    task automatic add_random_samples(int n);
        logic signed [31:0] a, r;
        int unsigned pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                a = $urandom;
                r = $urandom;
            end
            else
            begin
                a = 32'($urandom_range(2 * 180 * 65536)) - 32'(180 * 65536);
                r = 32'($urandom_range(2 * 500 * 65536)) - 32'(500 * 65536);
            end
            add_sample(a, r, $urandom_range(99) < 4);
        end
    endtask

    initial
    begin
        dt_reg = TIME_STEP_RST;
        qa_reg = ANGLE_NOISE_RST;
        qb_reg = BIAS_NOISE_RST;
        rm_reg = MEASURE_NOISE_RST;
        clear_filter_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed samples at reset settings: field extremes, restart from
        // fresh and mid-run, zero input
        send_idle = 24;
        recv_idle = 65;
        add_sample(32'sd0, 32'sd0, 1'b1);
        add_sample(32'sd0, 32'sd0, 1'b0);
        add_sample(32'sh7fffffff, 32'sd0, 1'b0);
        add_sample(32'sh80000000, 32'sd0, 1'b0);
        add_sample(32'sd0, 32'sh7fffffff, 1'b0);
        add_sample(32'sd0, 32'sh80000000, 1'b0);
        add_sample(32'sh7fffffff, 32'sh7fffffff, 1'b0);
        add_sample(32'sh80000000, 32'sh80000000, 1'b0);
        add_sample(32'sd655360, 32'sd65536, 1'b1);
        add_sample(32'sd655360, 32'sd65536, 1'b0);
        add_sample(-32'sd655360, -32'sd65536, 1'b0);
        add_sample(32'sh7fffffff, 32'sh80000000, 1'b1);
        add_sample(32'sd1, -32'sd1, 1'b0);
        add_sample(32'sd0, 32'sd0, 1'b1);
        // wait until every sample has been sent and everything has come back
        drain();

        // register extremes, then random settings; samples in between
        set_filter_regs('1, '1, '1, '1);
        add_sample(32'sd0, 32'sd0, 1'b1);
        add_random_samples(150);
        drain();
        set_filter_regs('0, '0, '0, '0);
        add_sample(32'sh7fffffff, 32'sh7fffffff, 1'b1);
        add_random_samples(150);
        drain();

        send_idle = 65;
        recv_idle = 24;
        set_filter_regs($urandom, $urandom, $urandom, $urandom);
        add_random_samples(150);
        drain();
        // large step with tiny measurement noise
        set_filter_regs('1, $urandom_range(65535), $urandom_range(65535), '0);
        add_sample(32'sd0, 32'sd0, 1'b1);
        add_random_samples(150);
        drain();

        send_idle = 0;
        recv_idle = 0;
        set_filter_regs($urandom, $urandom_range(1 << 20), $urandom_range(1 << 20),
                        $urandom_range(1 << 24));
        add_random_samples(150);
        drain();
        set_filter_regs(TIME_STEP_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST);
        add_sample(32'sd0, 32'sd0, 1'b1);
        add_random_samples(170);
        drain();

        repeat (LATENCY) @(posedge clk);
        if (errors == 0 && estimate_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // guard against a hang
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/kabf_pkg.sv
sv/kalman_angle_bias_filter_core.sv
sv/kabf_checker.sv
tb/tb_top.sv
